[hw/rtl/fssm_pkg.sv]
// fssm_pkg: shared types and constants of the flex sensor stick mapper.
// No dependencies; used by every module under hw/rtl except fssm_ram.
package fssm_pkg;

  // channel layout
  localparam int N_CH  = 3;
  localparam int SMP_W = 10;

  // item kind, carried on in_tuser
  localparam logic KIND_CAL  = 1'b0;
  localparam logic KIND_MEAS = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 11;
  localparam logic [CFG_IDX_W-1:0] REG_THR_DB = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_DB = 2'd1;
  localparam int THR_DB_W = 10;
  localparam int YAW_DB_W = 11;
  localparam logic [THR_DB_W-1:0] THR_DB_RST = 10'd5;
  localparam logic [YAW_DB_W-1:0] YAW_DB_RST = 11'd10;

  // calibration: 15 triples, baseline = floor(sum / 15) by reciprocal
  localparam int CAL_W      = 14;
  localparam int CAL_CNT_W  = 4;
  localparam logic [CAL_CNT_W-1:0] CAL_LAST = 4'd14;
  localparam int CAL_SHIFT  = 18;
  localparam int CAL_RECIP_W = 15;
  localparam logic [CAL_RECIP_W-1:0] CAL_RECIP = 15'd17477;

  // deviation widths
  localparam int DEV_T_W = 11;
  localparam int DEV_Y_W = 12;

  // output mapping
  localparam int PULSE_W = 14;
  localparam logic [PULSE_W-1:0] THR_IDLE   = 14'd1000;
  localparam logic [PULSE_W-1:0] YAW_CENTRE = 14'd1500;
  localparam int YAW_X_W = 15;
  localparam logic signed [YAW_X_W-1:0] YAW_OFFSET = 15'sd200;
  localparam logic signed [YAW_X_W-1:0] YAW_BASE   = 15'sd1000;

  // deviations handed from the averaging stage to the mapping stage
  typedef struct packed {
    logic signed [DEV_Y_W-1:0] yaw_dev;
    logic signed [DEV_T_W-1:0] thr_dev;
  } dev_t;

endpackage

[hw/rtl/fssm_ram.sv]
// fssm_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
module fssm_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/fssm_window.sv]
// fssm_window: input register, calibration and moving-average windows.
// Depends on fssm_pkg and fssm_ram.
module fssm_window #(
  parameter int WINDOW = 8,
  localparam int SUM_W = fssm_pkg::SMP_W + $clog2(WINDOW),
  localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_kind,
  input  logic [fssm_pkg::N_CH-1:0][fssm_pkg::SMP_W-1:0] in_smp,
  output logic m_valid,
  input  logic m_ready,
  output logic [fssm_pkg::N_CH-1:0][SUM_W-1:0] m_sum,
  output logic [fssm_pkg::N_CH-1:0][fssm_pkg::SMP_W-1:0] m_base
);

  localparam int N_CH  = fssm_pkg::N_CH;
  localparam int SMP_W = fssm_pkg::SMP_W;
  localparam int RAM_W = N_CH * SMP_W;
  localparam int CAL_W = fssm_pkg::CAL_W;
  localparam int CP_W  = CAL_W + fssm_pkg::CAL_RECIP_W;

  // stage 1: input register
  logic s1_v_r, s1_kind_r;
  logic [N_CH-1:0][SMP_W-1:0] s1_smp_r;
  logic s1_meas, s1_go, s2_free, win_we;

  // window state
  logic [WINDOW-1:0] valid_r;
  logic [POS_W-1:0] pos_r, pos_nxt, pos_wrap;
  logic [N_CH-1:0][SUM_W-1:0] sum_r, sum_nxt;
  logic [RAM_W-1:0] ram_q, last_r, old_word;
  logic hit_r;
  logic [N_CH-1:0][SMP_W-1:0] old_smp;

  // calibration state
  logic [N_CH-1:0][CAL_W-1:0] cal_sum_r, cal_tot;
  logic [fssm_pkg::CAL_CNT_W-1:0] cal_cnt_r;
  logic [N_CH-1:0][SMP_W-1:0] base_r, base_new;
  logic [CP_W-1:0] cal_prod [N_CH];

  // stage 2: output register
  logic s2_v_r;
  logic [N_CH-1:0][SUM_W-1:0] s2_sum_r;
  logic [N_CH-1:0][SMP_W-1:0] s2_base_r;

  assign s1_meas  = (s1_kind_r == fssm_pkg::KIND_MEAS);
  assign s2_free  = !s2_v_r || m_ready;
  assign s1_go    = s1_v_r && (!s1_meas || s2_free);
  assign in_ready = !s1_v_r || s1_go;
  assign win_we   = s1_go && s1_meas;

  assign pos_wrap = (pos_r == POS_W'(WINDOW - 1)) ? '0 : pos_r + POS_W'(1);
  assign pos_nxt  = win_we ? pos_wrap : pos_r;

  // read runs one step ahead: address of the next slot, so that the old
  // entry is ready when the beat reaches stage 1
  fssm_ram #(.WIDTH(RAM_W), .DEPTH(WINDOW)) u_win_ram (
    .clk   (clk),
    .we    (win_we),
    .waddr (pos_r),
    .wdata (s1_smp_r),
    .raddr (pos_nxt),
    .rdata (ram_q)
  );

  assign old_word = hit_r ? last_r : ram_q;

  always_comb begin
    for (int c = 0; c < N_CH; c++) begin
      old_smp[c]  = valid_r[pos_r] ? old_word[c*SMP_W +: SMP_W] : '0;
      sum_nxt[c]  = sum_r[c] - SUM_W'(old_smp[c]) + SUM_W'(s1_smp_r[c]);
      cal_tot[c]  = cal_sum_r[c] + CAL_W'(s1_smp_r[c]);
      cal_prod[c] = CP_W'(cal_tot[c]) * CP_W'(fssm_pkg::CAL_RECIP);
      base_new[c] = cal_prod[c][fssm_pkg::CAL_SHIFT +: SMP_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      valid_r   <= '0;
      pos_r     <= '0;
      sum_r     <= '0;
      hit_r     <= 1'b0;
      cal_sum_r <= '0;
      cal_cnt_r <= '0;
      base_r    <= '0;
    end else begin
      if (in_ready) begin
        s1_v_r <= in_valid;
      end
      if (win_we) begin
        s2_v_r         <= 1'b1;
        valid_r[pos_r] <= 1'b1;
        sum_r          <= sum_nxt;
      end else if (m_ready) begin
        s2_v_r <= 1'b0;
      end
      pos_r <= pos_nxt;
      hit_r <= win_we && (pos_r == pos_nxt);
      if (s1_go && !s1_meas) begin
        if (cal_cnt_r == fssm_pkg::CAL_LAST) begin
          base_r    <= base_new;
          cal_sum_r <= '0;
          cal_cnt_r <= '0;
        end else begin
          cal_sum_r <= cal_tot;
          cal_cnt_r <= cal_cnt_r + fssm_pkg::CAL_CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind_r <= in_kind;
      s1_smp_r  <= in_smp;
    end
    last_r <= s1_smp_r;
    if (win_we) begin
      s2_sum_r  <= sum_nxt;
      s2_base_r <= base_r;
    end
  end

  assign m_valid = s2_v_r;
  assign m_sum   = s2_sum_r;
  assign m_base  = s2_base_r;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(WINDOW - 1))
    else $error("window position past end");

  a_cal_range: assert property (@(posedge clk) disable iff (!rst_n)
    cal_cnt_r <= fssm_pkg::CAL_LAST)
    else $error("calibration count past end");

  a_slot_valid: assert property (@(posedge clk) disable iff (!rst_n)
    win_we |=> valid_r[$past(pos_r)] && s2_v_r)
    else $error("written slot not marked or beat lost");

  a_cal_no_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && !s1_meas && s2_v_r && m_ready) |=> !s2_v_r)
    else $error("calibration beat produced an average");

endmodule

[hw/rtl/fssm_average.sv]
// fssm_average: window sums to averages and baseline deviations.
// Depends on fssm_pkg.
module fssm_average #(
  parameter int WINDOW = 8,
  localparam int SUM_W = fssm_pkg::SMP_W + $clog2(WINDOW)
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic [fssm_pkg::N_CH-1:0][SUM_W-1:0] in_sum,
  input  logic [fssm_pkg::N_CH-1:0][fssm_pkg::SMP_W-1:0] in_base,
  output logic out_valid,
  input  logic out_ready,
  output fssm_pkg::dev_t out_dev
);

  localparam int N_CH    = fssm_pkg::N_CH;
  localparam int SMP_W   = fssm_pkg::SMP_W;
  localparam int DEV_T_W = fssm_pkg::DEV_T_W;
  localparam int DEV_Y_W = fssm_pkg::DEV_Y_W;
  // floor(x / WINDOW) = (x * RECIP) >> SHIFT, exact for x below 2**SUM_W
  localparam int SHIFT   = SUM_W + $clog2(WINDOW);
  localparam int RECIP_W = SHIFT + 1;
  localparam int unsigned RECIP = ((1 << SHIFT) + WINDOW - 1) / WINDOW;
  localparam int PROD_W  = SUM_W + RECIP_W;

  logic [PROD_W-1:0] prod [N_CH];
  logic [SMP_W-1:0]  avg  [N_CH];
  logic signed [DEV_T_W-1:0] e1, e2;
  fssm_pkg::dev_t dev_nxt, dev_r;
  logic v_r;

  always_comb begin
    for (int c = 0; c < N_CH; c++) begin
      prod[c] = PROD_W'(in_sum[c]) * PROD_W'(RECIP);
      avg[c]  = prod[c][SHIFT +: SMP_W];
    end
    dev_nxt.thr_dev = $signed({1'b0, in_base[0]}) - $signed({1'b0, avg[0]});
    e1 = $signed({1'b0, in_base[1]}) - $signed({1'b0, avg[1]});
    e2 = $signed({1'b0, in_base[2]}) - $signed({1'b0, avg[2]});
    dev_nxt.yaw_dev = DEV_Y_W'(e1) - DEV_Y_W'(e2);
  end

  assign in_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      dev_r <= dev_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_dev   = dev_r;

endmodule

[hw/rtl/fssm_map.sv]
// fssm_map: deadband test and linear maps to pulse widths, output register.
// Depends on fssm_pkg.
module fssm_map (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  fssm_pkg::dev_t in_dev,
  input  logic [fssm_pkg::THR_DB_W-1:0] thr_db,
  input  logic [fssm_pkg::YAW_DB_W-1:0] yaw_db,
  output logic out_valid,
  input  logic out_ready,
  output logic [fssm_pkg::PULSE_W-1:0] out_thr,
  output logic signed [fssm_pkg::PULSE_W-1:0] out_yaw
);

  localparam int PULSE_W = fssm_pkg::PULSE_W;
  localparam int DEV_T_W = fssm_pkg::DEV_T_W;
  localparam int DEV_Y_W = fssm_pkg::DEV_Y_W;
  localparam int X_W     = fssm_pkg::YAW_X_W;

  logic [PULSE_W-1:0] t_u, thr_nxt, thr_r;
  logic [DEV_Y_W-1:0] ad;
  logic signed [X_W-1:0] dx, v5, half;
  logic signed [PULSE_W-1:0] yaw_nxt, yaw_r;
  logic v_r;

  always_comb begin
    // throttle: 10*t + 1000 past the deadband
    t_u = PULSE_W'(in_dev.thr_dev[DEV_T_W-2:0]);
    if (in_dev.thr_dev > $signed({1'b0, thr_db})) begin
      thr_nxt = (t_u << 3) + (t_u << 1) + fssm_pkg::THR_IDLE;
    end else begin
      thr_nxt = fssm_pkg::THR_IDLE;
    end
    // yaw: (d + 200) * 5 / 2, rounded toward zero, + 1000
    ad   = in_dev.yaw_dev[DEV_Y_W-1] ? DEV_Y_W'(-in_dev.yaw_dev)
                                     : DEV_Y_W'(in_dev.yaw_dev);
    dx   = X_W'(in_dev.yaw_dev) + fssm_pkg::YAW_OFFSET;
    v5   = (dx <<< 2) + dx;
    half = (v5 + $signed(X_W'(v5[X_W-1]))) >>> 1;
    if (ad > {1'b0, yaw_db}) begin
      yaw_nxt = PULSE_W'(half + fssm_pkg::YAW_BASE);
    end else begin
      yaw_nxt = $signed(fssm_pkg::YAW_CENTRE);
    end
  end

  assign in_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      thr_r <= thr_nxt;
      yaw_r <= yaw_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_thr   = thr_r;
  assign out_yaw   = yaw_r;

endmodule

[hw/rtl/flex_sensor_stick_mapper_unit.sv]
// flex_sensor_stick_mapper_unit: top level of the flex sensor stick mapper.
// Depends on fssm_pkg, fssm_ram, fssm_window, fssm_average, fssm_map.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------
//  in_     | sink      | in_tvalid/tready   | tdata: 3 samples, tuser: kind
//  out_    | source    | out_tvalid/tready  | tdata: throttle, yaw pulse
//  cfg_    | sink      | cfg_we             | cfg_index, cfg_wdata
//
// One beat per cycle sustained while out_ is not back-pressured. A measurement
// beat reaches out_ after four register stages: input register, window sums,
// deviations, pulse output. The window store is one RAM read one slot ahead of
// the write position, so its single read port keeps pace with one beat per cycle.
// Reset (synchronous, active low) clears the sums, baselines, calibration
// count and the per-slot valid bits; unwritten slots read as zero, so no
// clearing pass is needed. Calibration beats are absorbed in stage 1.
// Back-pressure on out_ stops each stage only when the next one is full.
module flex_sensor_stick_mapper_unit #(
  parameter int WINDOW = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,  // throttle_sample[9:0], yaw_left_sample[19:10],
                                 // yaw_right_sample[29:20], zero pad
  input  logic        in_tuser,  // kind: 0 calibration, 1 measurement
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata, // throttle_pulse[13:0], yaw_pulse[27:14] (signed),
                                 // zero pad
  // configuration
  input  logic        cfg_we,
  input  logic [fssm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fssm_pkg::CFG_DAT_W-1:0] cfg_wdata
);

  localparam int N_CH    = fssm_pkg::N_CH;
  localparam int SMP_W   = fssm_pkg::SMP_W;
  localparam int SUM_W   = SMP_W + $clog2(WINDOW);
  localparam int PULSE_W = fssm_pkg::PULSE_W;

  // deadband registers
  logic [fssm_pkg::THR_DB_W-1:0] thr_db_r;
  logic [fssm_pkg::YAW_DB_W-1:0] yaw_db_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_db_r <= fssm_pkg::THR_DB_RST;
      yaw_db_r <= fssm_pkg::YAW_DB_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fssm_pkg::REG_THR_DB: thr_db_r <= cfg_wdata[fssm_pkg::THR_DB_W-1:0];
        fssm_pkg::REG_YAW_DB: yaw_db_r <= cfg_wdata[fssm_pkg::YAW_DB_W-1:0];
        default: ; // index beyond the register list: ignored
      endcase
    end
  end

  // unpack the sample triple
  logic [N_CH-1:0][SMP_W-1:0] in_smp;
  assign in_smp = in_tdata[N_CH*SMP_W-1:0];

  // stage 1 -> 2: window sums with the baselines they are measured against
  logic s2_valid, s2_ready;
  logic [N_CH-1:0][SUM_W-1:0] s2_sum;
  logic [N_CH-1:0][SMP_W-1:0] s2_base;

  fssm_window #(.WINDOW(WINDOW)) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_kind  (in_tuser),
    .in_smp   (in_smp),
    .m_valid  (s2_valid),
    .m_ready  (s2_ready),
    .m_sum    (s2_sum),
    .m_base   (s2_base)
  );

  // stage 3: deviations
  logic s3_valid, s3_ready;
  fssm_pkg::dev_t s3_dev;

  fssm_average #(.WINDOW(WINDOW)) u_average (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_sum    (s2_sum),
    .in_base   (s2_base),
    .out_valid (s3_valid),
    .out_ready (s3_ready),
    .out_dev   (s3_dev)
  );

  // stage 4: pulse mapping and output register
  logic [PULSE_W-1:0] thr_pulse;
  logic signed [PULSE_W-1:0] yaw_pulse;

  fssm_map u_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s3_valid),
    .in_ready  (s3_ready),
    .in_dev    (s3_dev),
    .thr_db    (thr_db_r),
    .yaw_db    (yaw_db_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_thr   (thr_pulse),
    .out_yaw   (yaw_pulse)
  );

  assign out_tdata = {4'b0, yaw_pulse, thr_pulse};

  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat out of reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result beat changed");

  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!s2_valid && !s3_valid && !out_tvalid) |-> in_tready)
    else $error("input stalled with empty pipeline");

endmodule
